// ===== hdl/fai_pkg.sv =====
// Package: shared constants, codes and types of the fluid-aware trilinear interpolator.
`timescale 1ns / 1ps
package fai_pkg;

	localparam int MAX_SIZE_DEF   = 16;
	localparam int CHANNELS_DEF   = 3;
	localparam int BATCHES_DEF    = 2;
	localparam int POS_FRAC_DEF   = 10;

	localparam int VAL_W   = 32;
	localparam int POS_W   = 16;
	localparam int CELL_W  = 4;
	localparam int CH_W    = 2;
	localparam int BT_W    = 1;
	localparam int SIZE_W  = 5;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		ACT_WR_VALUE    = 2'd0,
		ACT_WR_FLUID    = 2'd1,
		ACT_QUERY       = 2'd2,
		ACT_QUERY_FLUID = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE_X  = 2'd0,
		REG_SIZE_Y  = 2'd1,
		REG_SIZE_Z  = 2'd2,
		REG_THREE_D = 2'd3
	} cfg_reg_t;

	// Control that travels with one blend operation.
	typedef struct packed {
		logic valid;
		logic fa;
		logic fb;
	} blend_ctl_t;

endpackage

// ===== hdl/fai_if.sv =====
// Interfaces: request, result and configuration channels.
`timescale 1ns / 1ps
interface fai_req_if;
	logic                   valid;
	logic                   ready;
	logic [1:0]             action;
	logic [3:0]             cell_x;
	logic [3:0]             cell_y;
	logic [3:0]             cell_z;
	logic [1:0]             channel;
	logic [0:0]             batch;
	logic signed [31:0]     cell_value;
	logic [0:0]             cell_fluid;
	logic signed [15:0]     pos_x;
	logic signed [15:0]     pos_y;
	logic signed [15:0]     pos_z;
	modport source (output valid, action, cell_x, cell_y, cell_z, channel, batch,
		cell_value, cell_fluid, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, action, cell_x, cell_y, cell_z, channel, batch,
		cell_value, cell_fluid, pos_x, pos_y, pos_z, output ready);
endinterface

interface fai_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] interp_value;
	logic [0:0]         no_fluid_fallback;
	modport source (output valid, interp_value, no_fluid_fallback, input ready);
	modport sink (input valid, interp_value, no_fluid_fallback, output ready);
endinterface

interface fai_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [4:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/fai_grid_mem.sv =====
// Grid storage: value memory and fluid mark memory, one port each, registered read.
`timescale 1ns / 1ps
module fai_grid_mem #(
	parameter int MAX_SIZE = fai_pkg::MAX_SIZE_DEF,
	parameter int CHANNELS = fai_pkg::CHANNELS_DEF,
	parameter int BATCHES  = fai_pkg::BATCHES_DEF,
	localparam int CELLS   = MAX_SIZE * MAX_SIZE * MAX_SIZE,
	localparam int VDEPTH  = BATCHES * CHANNELS * CELLS,
	localparam int FDEPTH  = BATCHES * CELLS,
	localparam int VAW     = $clog2(VDEPTH),
	localparam int FAW     = $clog2(FDEPTH)
) (
	input  logic                  clk,
	input  logic [VAW-1:0]        v_addr,
	input  logic                  v_we,
	input  logic signed [31:0]    v_wdata,
	output logic signed [31:0]    v_rdata,
	input  logic [FAW-1:0]        f_addr,
	input  logic                  f_we,
	input  logic                  f_wdata,
	output logic                  f_rdata
);
	import fai_pkg::*;

	logic signed [VAL_W-1:0] values_mem [VDEPTH];
	logic                    marks_mem  [FDEPTH];

	always_ff @(posedge clk) begin
		if (v_we) begin
			values_mem[v_addr] <= v_wdata;
		end
		v_rdata <= values_mem[v_addr];
	end

	always_ff @(posedge clk) begin
		if (f_we) begin
			marks_mem[f_addr] <= f_wdata;
		end
		f_rdata <= marks_mem[f_addr];
	end

endmodule

// ===== hdl/fai_blend_unit.sv =====
// Shared blend unit: a*(1-w) + b*w rounded, with fluid pass-through, two stages.
`timescale 1ns / 1ps
module fai_blend_unit #(
	parameter int POS_FRAC_BITS = fai_pkg::POS_FRAC_DEF,
	localparam int WW = POS_FRAC_BITS + 1,
	localparam int PW = 33 + WW + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fai_pkg::blend_ctl_t     ctl,
	input  logic signed [31:0]      a,
	input  logic signed [31:0]      b,
	input  logic [WW-1:0]           w,
	output logic                    out_valid,
	output logic signed [31:0]      out_value,
	output logic                    out_fluid
);
	import fai_pkg::*;

	localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (POS_FRAC_BITS - 1);

	blend_ctl_t             ctl_s1;
	logic signed [PW-1:0]   prod_s1;
	logic signed [31:0]     a_s1;
	logic signed [31:0]     b_s1;
	logic signed [32:0]     diff;
	logic signed [PW:0]     sum;

	// a*W + (b-a)*w equals a*(W-w) + b*w exactly
	assign diff = 33'(b) - 33'(a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			out_valid <= 1'b0;
		end else begin
			ctl_s1    <= ctl;
			out_valid <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(diff * $signed({1'b0, w}));
		a_s1    <= a;
		b_s1    <= b;
	end

	// Floor of (x + half) matches round-half-up for both signs
	assign sum = ((PW+1)'(a_s1) <<< POS_FRAC_BITS) + (PW+1)'(prod_s1) + HALF;

	always_ff @(posedge clk) begin
		if (!ctl_s1.fa && !ctl_s1.fb) begin
			out_value <= '0;
			out_fluid <= 1'b0;
		end else if (!ctl_s1.fa) begin
			out_value <= b_s1;
			out_fluid <= 1'b1;
		end else if (!ctl_s1.fb) begin
			out_value <= a_s1;
			out_fluid <= 1'b1;
		end else begin
			out_value <= 32'(sum >>> POS_FRAC_BITS);
			out_fluid <= 1'b1;
		end
	end

endmodule

// ===== hdl/fluid_aware_trilinear_interp_top.sv =====
// Top level: fluid-aware bilinear/trilinear interpolator with sequencer and grid storage.
`timescale 1ns / 1ps
// Holds per-batch, per-channel value grids and per-batch fluid marks in two single-port
// memories, loaded by write transactions (no result). A query transaction reads its
// corner cells one per cycle from the registered memory read port (4 in 2D, 8 in 3D),
// then runs its pairwise blends one after another through one shared two-stage blend
// unit (3 blends in 2D, 7 in 3D); a fluid-aware query that finds no fluid corner runs
// the blends a second time in plain mode and raises no_fluid_fallback. The block takes
// one transaction at a time; the result waits in an output register, and the block
// returns to idle once the result register is free. Memories come up undefined:
// software loads every cell it will query. Configuration is to be written only while
// idle; the block itself does not enforce it.
module fluid_aware_trilinear_interp_top #(
	parameter int MAX_SIZE      = fai_pkg::MAX_SIZE_DEF,
	parameter int CHANNELS      = fai_pkg::CHANNELS_DEF,
	parameter int BATCHES       = fai_pkg::BATCHES_DEF,
	parameter int POS_FRAC_BITS = fai_pkg::POS_FRAC_DEF
) (
	input logic     clk,
	input logic     arst_n,
	fai_req_if.sink req,
	fai_rsp_if.source rsp,
	fai_cfg_if.sink cfg
);
	import fai_pkg::*;

	localparam int CELLS  = MAX_SIZE * MAX_SIZE * MAX_SIZE;
	localparam int VAW    = $clog2(BATCHES * CHANNELS * CELLS);
	localparam int FAW    = $clog2(BATCHES * CELLS);
	localparam int IW     = $clog2(MAX_SIZE);
	localparam int WW     = POS_FRAC_BITS + 1;
	localparam logic [WW-1:0] W_ONE = WW'(1) << POS_FRAC_BITS;
	localparam logic signed [16:0] HALF = 17'(1) << (POS_FRAC_BITS - 1);
	localparam logic [7:0] MAX8 = 8'(MAX_SIZE);

	typedef struct packed {
		logic [IW-1:0] idx;
		logic [WW-1:0] w;
	} axis_t;

	typedef enum logic [2:0] {S_IDLE, S_READ, S_ISSUE, S_WAIT, S_OUT} state_t;

	// Split a position into clamped lower index and upper weight
	function automatic axis_t axis_calc(input logic [15:0] pos, input logic [7:0] sz);
		logic signed [16:0] p;
		logic [16:0]        i;
		axis_t              r;
		p = $signed({pos[15], pos}) - HALF;
		i = 17'(p >>> POS_FRAC_BITS);
		r.idx = '0;
		r.w   = '0;
		if (!p[16]) begin
			if (i >= 17'(sz) - 17'd1) begin
				r.idx = IW'(sz - 8'd2);
				r.w   = W_ONE;
			end else begin
				r.idx = i[IW-1:0];
				r.w   = {1'b0, p[POS_FRAC_BITS-1:0]};
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] clamp_size(input logic [4:0] s, input logic [7:0] lo);
		if (8'(s) < lo) begin
			return lo;
		end else if (8'(s) > MAX8) begin
			return MAX8;
		end
		return 8'(s);
	endfunction

	// Configuration registers
	logic [4:0] size_x_q, size_y_q, size_z_q;
	logic       three_d_q;

	// Sequencer and query context
	state_t                  state_q;
	logic [3:0]              rd_q;
	logic [2:0]              step_q;
	logic [IW-1:0]           xi_q, yi_q, z0_q, z1_q;
	logic [WW-1:0]           s_q, t_q, f_q;
	logic [VAW-1:0]          vbase_q;
	logic [FAW-1:0]          fbase_q;
	logic                    aware_q, query_fluid_q, three_q, fallback_q;
	logic signed [31:0]      corner_v_q [8];
	logic [7:0]              corner_f_q;
	logic signed [31:0]      r0_q, r1_q, r2_q, r3_q;
	logic                    rf0_q, rf1_q, rf2_q, rf3_q;
	logic                    rsp_valid_q;
	logic signed [31:0]      rsp_value_q;
	logic                    rsp_flag_q;

	// Memory port signals
	logic [VAW-1:0]          v_addr;
	logic                    v_we;
	logic signed [31:0]      v_rdata;
	logic [FAW-1:0]          f_addr;
	logic                    f_we;
	logic                    f_rdata;

	// Blend unit signals
	blend_ctl_t              bl_ctl;
	logic signed [31:0]      bl_a, bl_b;
	logic [WW-1:0]           bl_w;
	logic                    bl_valid;
	logic signed [31:0]      bl_value;
	logic                    bl_fluid;

	logic                    req_fire, is_query, wr_ok;
	logic [7:0]              sx, sy, sz;
	axis_t                   ax, ay, az;
	logic [1:0]              q_ch;
	logic [BT_W-1:0]         q_bt;
	logic [2:0]              rd_k;
	logic [IW-1:0]           cx, cy, cz;
	logic [31:0]             w_cell, r_cell;
	logic [7:0]              cf;
	logic [3:0]              n_corners;
	logic [2:0]              last_step;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;
	assign is_query  = (req.action == ACT_QUERY) || (req.action == ACT_QUERY_FLUID);

	assign sx = clamp_size(size_x_q, 8'd2);
	assign sy = clamp_size(size_y_q, 8'd2);
	assign sz = clamp_size(size_z_q, 8'd1);
	assign ax = axis_calc(req.pos_x, sx);
	assign ay = axis_calc(req.pos_y, sy);
	assign az = axis_calc(req.pos_z, sz);

	// Saturate query channel and batch
	assign q_ch = (32'(req.channel) >= CHANNELS) ? 2'(CHANNELS - 1) : req.channel;
	assign q_bt = (32'(req.batch) >= BATCHES) ? BT_W'(BATCHES - 1) : req.batch;

	// Drop writes outside the stored grid
	assign wr_ok = (32'(req.cell_x) < MAX_SIZE) && (32'(req.cell_y) < MAX_SIZE)
		&& (32'(req.cell_z) < MAX_SIZE) && (32'(req.batch) < BATCHES)
		&& ((req.action != ACT_WR_VALUE) || (32'(req.channel) < CHANNELS));

	assign w_cell = (32'(req.cell_z) * MAX_SIZE + 32'(req.cell_y)) * MAX_SIZE
		+ 32'(req.cell_x);

	// Corner k: bit 0 steps y, bit 1 steps x, bit 2 picks the upper z plane
	assign rd_k   = rd_q[2:0];
	assign cx     = xi_q + IW'(rd_k[1]);
	assign cy     = yi_q + IW'(rd_k[0]);
	assign cz     = rd_k[2] ? z1_q : z0_q;
	assign r_cell = (32'(cz) * MAX_SIZE + 32'(cy)) * MAX_SIZE + 32'(cx);

	assign n_corners = three_q ? 4'd8 : 4'd4;
	assign last_step = three_q ? 3'd6 : 3'd2;

	always_comb begin
		if (state_q == S_IDLE) begin
			v_addr = VAW'((32'(req.batch) * CHANNELS + 32'(req.channel)) * CELLS + w_cell);
			f_addr = FAW'(32'(req.batch) * CELLS + w_cell);
		end else begin
			v_addr = vbase_q + VAW'(r_cell);
			f_addr = fbase_q + FAW'(r_cell);
		end
		v_we = req_fire && wr_ok && (req.action == ACT_WR_VALUE);
		f_we = req_fire && wr_ok && (req.action == ACT_WR_FLUID);
	end

	// A corner counts as fluid when its mark is set or the pass is plain
	assign cf = corner_f_q | {8{~aware_q}};

	// Operand selection per blend step: y pairs, then x, for each z plane, then z
	always_comb begin
		bl_a = '0;
		bl_b = '0;
		bl_w = '0;
		bl_ctl.fa = 1'b0;
		bl_ctl.fb = 1'b0;
		case (step_q)
			3'd0: begin
				bl_a = corner_v_q[0]; bl_b = corner_v_q[1]; bl_w = t_q;
				bl_ctl.fa = cf[0]; bl_ctl.fb = cf[1];
			end
			3'd1: begin
				bl_a = corner_v_q[2]; bl_b = corner_v_q[3]; bl_w = t_q;
				bl_ctl.fa = cf[2]; bl_ctl.fb = cf[3];
			end
			3'd2, 3'd5: begin
				bl_a = r0_q; bl_b = r1_q; bl_w = s_q;
				bl_ctl.fa = rf0_q; bl_ctl.fb = rf1_q;
			end
			3'd3: begin
				bl_a = corner_v_q[4]; bl_b = corner_v_q[5]; bl_w = t_q;
				bl_ctl.fa = cf[4]; bl_ctl.fb = cf[5];
			end
			3'd4: begin
				bl_a = corner_v_q[6]; bl_b = corner_v_q[7]; bl_w = t_q;
				bl_ctl.fa = cf[6]; bl_ctl.fb = cf[7];
			end
			3'd6: begin
				bl_a = r2_q; bl_b = r3_q; bl_w = f_q;
				bl_ctl.fa = rf2_q; bl_ctl.fb = rf3_q;
			end
			default: begin
				bl_a = '0;
			end
		endcase
		bl_ctl.valid = (state_q == S_ISSUE);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q  <= 5'd16;
			size_y_q  <= 5'd16;
			size_z_q  <= 5'd16;
			three_d_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_SIZE_X:  size_x_q  <= cfg.data;
				REG_SIZE_Y:  size_y_q  <= cfg.data;
				REG_SIZE_Z:  size_z_q  <= cfg.data;
				REG_THREE_D: three_d_q <= cfg.data[0];
				default:     three_d_q <= three_d_q;
			endcase
		end
	end

	// Sequencer: capture query, read corners, run blends, hand off result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			rd_q          <= '0;
			step_q        <= '0;
			aware_q       <= 1'b0;
			query_fluid_q <= 1'b0;
			three_q       <= 1'b0;
			fallback_q    <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			// Drop the taken result; the hand-off state reloads it on its own
			if (rsp_valid_q && rsp.ready && (state_q != S_OUT)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire && is_query) begin
						aware_q       <= (req.action == ACT_QUERY_FLUID);
						query_fluid_q <= (req.action == ACT_QUERY_FLUID);
						three_q       <= three_d_q;
						fallback_q    <= 1'b0;
						rd_q          <= '0;
						step_q        <= '0;
						state_q       <= S_READ;
					end
				end
				S_READ: begin
					if (rd_q != 4'd0) begin
						corner_v_q[3'(rd_q - 4'd1)] <= v_rdata;
						corner_f_q[3'(rd_q - 4'd1)] <= f_rdata;
					end
					if (rd_q == n_corners) begin
						state_q <= S_ISSUE;
					end
					rd_q <= rd_q + 4'd1;
				end
				S_ISSUE: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (bl_valid) begin
						case (step_q)
							3'd0, 3'd3: begin r0_q <= bl_value; rf0_q <= bl_fluid; end
							3'd1, 3'd4: begin r1_q <= bl_value; rf1_q <= bl_fluid; end
							3'd5:       begin r3_q <= bl_value; rf3_q <= bl_fluid; end
							default:    begin r2_q <= bl_value; rf2_q <= bl_fluid; end
						endcase
						if (step_q == last_step) begin
							if (aware_q && !bl_fluid) begin
								// no fluid corner: rerun blends in plain mode
								aware_q    <= 1'b0;
								fallback_q <= 1'b1;
								step_q     <= '0;
								state_q    <= S_ISSUE;
							end else begin
								state_q <= S_OUT;
							end
						end else begin
							step_q  <= step_q + 3'd1;
							state_q <= S_ISSUE;
						end
					end
				end
				S_OUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_value_q <= r2_q;
						rsp_flag_q  <= fallback_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Query context: indices, weights and memory bases
	always_ff @(posedge clk) begin
		if (req_fire && is_query) begin
			xi_q    <= ax.idx;
			yi_q    <= ay.idx;
			s_q     <= ax.w;
			t_q     <= ay.w;
			vbase_q <= VAW'((32'(q_bt) * CHANNELS + 32'(q_ch)) * CELLS);
			fbase_q <= FAW'(32'(q_bt) * CELLS);
			if (!three_d_q) begin
				z0_q <= '0;
				z1_q <= '0;
				f_q  <= '0;
			end else if (sz < 8'd2) begin
				z0_q <= '0;
				z1_q <= '0;
				f_q  <= '0;
			end else begin
				z0_q <= az.idx;
				z1_q <= az.idx + IW'(1);
				f_q  <= az.w;
			end
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.interp_value      = rsp_value_q;
	assign rsp.no_fluid_fallback = rsp_flag_q;

	fai_grid_mem #(
		.MAX_SIZE (MAX_SIZE),
		.CHANNELS (CHANNELS),
		.BATCHES  (BATCHES)
	) u_grid_mem (
		.clk     (clk),
		.v_addr  (v_addr),
		.v_we    (v_we),
		.v_wdata (req.cell_value),
		.v_rdata (v_rdata),
		.f_addr  (f_addr),
		.f_we    (f_we),
		.f_wdata (req.cell_fluid),
		.f_rdata (f_rdata)
	);

	fai_blend_unit #(
		.POS_FRAC_BITS (POS_FRAC_BITS)
	) u_blend_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (bl_ctl),
		.a         (bl_a),
		.b         (bl_b),
		.w         (bl_w),
		.out_valid (bl_valid),
		.out_value (bl_value),
		.out_fluid (bl_fluid)
	);

	// Blend results arrive only while the sequencer waits for them
	assert property (@(posedge clk) disable iff (!arst_n) bl_valid |-> state_q == S_WAIT)
		else $error("blend result outside wait state");

	// Fallback flag only for a fluid-aware query
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) && fallback_q |-> query_fluid_q && !aware_q)
		else $error("fallback on plain query");

	// Blend steps stay within the pass for the current dimension
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ISSUE) |-> step_q <= last_step)
		else $error("blend step past last");

	// A finished result is handed off only into a free or draining output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) && rsp_valid_q && !rsp.ready |=> state_q == S_OUT)
		else $error("result overwritten");

endmodule

// ===== sim/fluid_aware_trilinear_interp_top_tb.sv =====
// Testbench: fluid_aware_trilinear_interp_top checked against an in-bench interpolation predictor.
`timescale 1ns / 1ps
module fluid_aware_trilinear_interp_top_tb;
	import fai_pkg::*;

	localparam int GRID_DIM   = 16;
	localparam int PLANE      = GRID_DIM * GRID_DIM * GRID_DIM;
	localparam int NUM_CH     = 3;
	localparam int NUM_BT     = 2;
	localparam int FRAC       = 10;
	localparam longint W_ONE  = 1 << FRAC;
	localparam longint W_HALF = 1 << (FRAC - 1);
	// Longest query: 3D fluid-aware with plain fallback, plus margin.
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 1000000;
	// Transactions per random phase, corner preloads included.
	localparam int PHASE_TXNS   = 100;

	typedef struct {
		action_t            act;
		logic [3:0]         x, y, z;
		logic [1:0]         ch;
		logic               bt;
		logic signed [31:0] val;
		logic               fl;
		logic signed [15:0] px, py, pz;
	} txn_t;

	typedef struct {
		logic signed [31:0] value;
		logic               fallback;
	} interp_t;

	logic clk;
	logic arst_n;
	fai_req_if req_ch();
	fai_rsp_if rsp_ch();
	fai_cfg_if cfg_ch();

	fluid_aware_trilinear_interp_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// Predictor state: mirrored grid, marks, written masks and registers.
	logic signed [31:0] grid_mem [NUM_BT][NUM_CH][PLANE];
	bit                 fluid_mem [NUM_BT][PLANE];
	bit                 grid_loaded [NUM_BT][NUM_CH][PLANE];
	bit                 mark_loaded [NUM_BT][PLANE];
	logic [4:0]         reg_sx, reg_sy, reg_sz;
	logic               reg_3d;

	interp_t pending_interp[$];
	int      err_count;
	int      cycle_count;
	int      sent_count;
	bit      no_idle;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("fluid_aware_trilinear_interp_top test failed");
			$finish;
		end
	end

	task automatic report(input string what, input longint got, input longint want);
		err_count++;
		$display("MISMATCH %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
	endtask

	// ---------------- predictor ----------------

	function automatic int clamp_dim(input logic [4:0] s, input int lo);
		if (s < lo) return lo;
		if (s > GRID_DIM) return GRID_DIM;
		return int'(s);
	endfunction

	// Split a position into lower cell index and upper weight, clamped to borders.
	function automatic void split_axis(input logic signed [15:0] pos, input int sz,
			output int idx, output longint w1);
		longint p;
		p = longint'(pos) - W_HALF;
		if (p < 0) begin
			idx = 0;
			w1 = 0;
			return;
		end
		idx = int'(p >>> FRAC);
		w1 = p & (W_ONE - 1);
		if (idx >= sz - 1) begin
			idx = sz - 2;
			w1 = W_ONE;
		end
	endfunction

	// One pairwise blend; non-fluid inputs drop out, rounding is half up.
	function automatic void mix(input longint va, input bit fa, input longint vb, input bit fb,
			input longint w1, output longint v, output bit f);
		if (!fa && !fb) begin
			v = 0;
			f = 0;
		end else if (!fa) begin
			v = vb;
			f = 1;
		end else if (!fb) begin
			v = va;
			f = 1;
		end else begin
			v = (va * (W_ONE - w1) + vb * w1 + W_HALF) >>> FRAC;
			f = 1;
		end
	endfunction

	function automatic int cell_addr(input int x, input int y, input int z);
		return (z * GRID_DIM + y) * GRID_DIM + x;
	endfunction

	// Corner cell indices of a query: x0, y0, lower and upper z.
	function automatic void corner_box(input logic signed [15:0] px, py, pz,
			output int xi, output int yi, output int z0, output int z1,
			output longint s1, output longint t1, output longint f1);
		int sz;
		sz = clamp_dim(reg_sz, 1);
		split_axis(px, clamp_dim(reg_sx, 2), xi, s1);
		split_axis(py, clamp_dim(reg_sy, 2), yi, t1);
		z0 = 0;
		z1 = 0;
		f1 = 0;
		if (reg_3d && sz >= 2) begin
			split_axis(pz, sz, z0, f1);
			z1 = z0 + 1;
		end
	endfunction

	function automatic void blend_plane(input int xi, yi, z, input longint s1, t1,
			input int ch, bt, input bit aware, output longint v, output bit f);
		longint va, vb, vc, vd, vab, vcd;
		bit fa, fb, fc, fd, fab, fcd;
		va = grid_mem[bt][ch][cell_addr(xi, yi, z)];
		vb = grid_mem[bt][ch][cell_addr(xi, yi + 1, z)];
		vc = grid_mem[bt][ch][cell_addr(xi + 1, yi, z)];
		vd = grid_mem[bt][ch][cell_addr(xi + 1, yi + 1, z)];
		fa = aware ? fluid_mem[bt][cell_addr(xi, yi, z)] : 1'b1;
		fb = aware ? fluid_mem[bt][cell_addr(xi, yi + 1, z)] : 1'b1;
		fc = aware ? fluid_mem[bt][cell_addr(xi + 1, yi, z)] : 1'b1;
		fd = aware ? fluid_mem[bt][cell_addr(xi + 1, yi + 1, z)] : 1'b1;
		mix(va, fa, vb, fb, t1, vab, fab);
		mix(vc, fc, vd, fd, t1, vcd, fcd);
		mix(vab, fab, vcd, fcd, s1, v, f);
	endfunction

	function automatic void interpolate(input txn_t it, input bit aware,
			output longint v, output bit f);
		int xi, yi, z0, z1, ch, bt;
		longint s1, t1, f1, v0, v1;
		bit g0, g1;
		ch = (it.ch >= NUM_CH) ? NUM_CH - 1 : int'(it.ch);
		bt = int'(it.bt);
		corner_box(it.px, it.py, it.pz, xi, yi, z0, z1, s1, t1, f1);
		if (reg_3d) begin
			blend_plane(xi, yi, z0, s1, t1, ch, bt, aware, v0, g0);
			blend_plane(xi, yi, z1, s1, t1, ch, bt, aware, v1, g1);
			mix(v0, g0, v1, g1, f1, v, f);
		end else begin
			blend_plane(xi, yi, 0, s1, t1, ch, bt, aware, v, f);
		end
	endfunction

	// Update the mirror for one accepted transaction; queue the expected result.
	function automatic void apply_txn(input txn_t it);
		int c;
		longint v;
		bit f, flag;
		interp_t r;
		c = cell_addr(it.x, it.y, it.z);
		case (it.act)
			ACT_WR_VALUE: begin
				if (it.ch < NUM_CH) begin
					grid_mem[it.bt][it.ch][c] = it.val;
					grid_loaded[it.bt][it.ch][c] = 1;
				end
			end
			ACT_WR_FLUID: begin
				fluid_mem[it.bt][c] = it.fl;
				mark_loaded[it.bt][c] = 1;
			end
			default: begin
				flag = 0;
				interpolate(it, it.act == ACT_QUERY_FLUID, v, f);
				if (it.act == ACT_QUERY_FLUID && !f) begin
					interpolate(it, 1'b0, v, f);
					flag = 1;
				end
				if (v > 64'sd2147483647) v = 64'sd2147483647;
				if (v < -64'sd2147483648) v = -64'sd2147483648;
				r.value = v[31:0];
				r.fallback = flag;
				pending_interp.push_back(r);
			end
		endcase
	endfunction

	// ---------------- drivers ----------------

	task automatic idle_gap();
		int r, n;
		r = $urandom_range(0, 99);
		n = 0;
		if (!no_idle) begin
			if (r >= 95) n = $urandom_range(10, 40);
			else if (r >= 60) n = $urandom_range(1, 3);
		end
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Drive one request and hold it until the block takes it.
	task automatic send_txn(input txn_t it);
		req_ch.valid      <= 1'b1;
		req_ch.action     <= it.act;
		req_ch.cell_x     <= it.x;
		req_ch.cell_y     <= it.y;
		req_ch.cell_z     <= it.z;
		req_ch.channel    <= it.ch;
		req_ch.batch      <= it.bt;
		req_ch.cell_value <= it.val;
		req_ch.cell_fluid <= it.fl;
		req_ch.pos_x      <= it.px;
		req_ch.pos_y      <= it.py;
		req_ch.pos_z      <= it.pz;
		do @(posedge clk); while (!req_ch.ready);
		sent_count++;
		apply_txn(it);
		idle_gap();
	endtask

	function automatic txn_t make_write(input action_t act, input int x, y, z, ch, bt,
			input logic signed [31:0] val, input bit fl);
		txn_t it;
		it.act = act;
		it.x = x;
		it.y = y;
		it.z = z;
		it.ch = ch;
		it.bt = bt;
		it.val = val;
		it.fl = fl;
		it.px = $urandom;
		it.py = $urandom;
		it.pz = $urandom;
		return it;
	endfunction

	function automatic txn_t make_query(input bit aware, input int ch, bt,
			input logic signed [15:0] px, py, pz);
		txn_t it;
		it = make_write(aware ? ACT_QUERY_FLUID : ACT_QUERY, $urandom_range(0, 15),
			$urandom_range(0, 15), $urandom_range(0, 15), ch, bt, $urandom, $urandom_range(0, 1));
		it.px = px;
		it.py = py;
		it.pz = pz;
		return it;
	endfunction

	// Load every corner the query will read that was never written, then send it.
	task automatic send_query(input txn_t it);
		int xi, yi, z0, z1, ch, zz;
		longint s1, t1, f1;
		ch = (it.ch >= NUM_CH) ? NUM_CH - 1 : int'(it.ch);
		corner_box(it.px, it.py, it.pz, xi, yi, z0, z1, s1, t1, f1);
		for (int k = 0; k < 8; k++) begin
			zz = k[2] ? z1 : z0;
			if (!grid_loaded[it.bt][ch][cell_addr(xi + k[0], yi + k[1], zz)])
				send_txn(make_write(ACT_WR_VALUE, xi + k[0], yi + k[1], zz, ch, it.bt,
					$urandom, 0));
			if (!mark_loaded[it.bt][cell_addr(xi + k[0], yi + k[1], zz)])
				send_txn(make_write(ACT_WR_FLUID, xi + k[0], yi + k[1], zz, ch, it.bt,
					$urandom, $urandom_range(0, 3) != 0));
		end
		send_txn(it);
	endtask

	// Wait until all results are back and the block has had time to settle.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_interp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [4:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_SIZE_X:  reg_sx = data;
			REG_SIZE_Y:  reg_sy = data;
			REG_SIZE_Z:  reg_sz = data;
			REG_THREE_D: reg_3d = data[0];
		endcase
		@(posedge clk);
	endtask

	task automatic set_geometry(input logic [4:0] sx, sy, sz, input logic td);
		wait_drained();
		write_reg(REG_SIZE_X, sx);
		write_reg(REG_SIZE_Y, sy);
		write_reg(REG_SIZE_Z, sz);
		write_reg(REG_THREE_D, {4'd0, td});
	endtask

	// Random position: mostly inside the active grid span, sometimes anywhere.
	function automatic logic signed [15:0] rand_pos(input logic [4:0] s);
		int span;
		span = (clamp_dim(s, 1) + 1) * int'(W_ONE);
		if ($urandom_range(0, 3) == 0) return $urandom;
		return $urandom_range(0, span) - int'(W_HALF);
	endfunction

	// ---------------- checker ----------------

	always @(posedge clk) begin
		interp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_interp.size() == 0) begin
				report("unexpected result", rsp_ch.interp_value, 0);
			end else begin
				want = pending_interp.pop_front();
				if (rsp_ch.interp_value !== want.value)
					report("interp_value", rsp_ch.interp_value, want.value);
				if (rsp_ch.no_fluid_fallback !== want.fallback)
					report("no_fluid_fallback", rsp_ch.no_fluid_fallback, want.fallback);
			end
		end
	end

	// Result-side backpressure: mostly ready, occasional long stalls.
	int stall_left;
	always @(posedge clk) begin
		if (no_idle) begin
			rsp_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 3) begin
			stall_left <= $urandom_range(10, 50);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= $urandom_range(0, 99) < 75;
		end
	end

	// ---------------- tests ----------------

	// Reset geometry (16x16x16, 3D): border clamps and full-range positions.
	task automatic test_reset_geometry();
		logic signed [15:0] edge_pos[6] = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd512,
			16'sd1024, 16'sd15871};
		for (int i = 0; i < 6; i++)
			send_query(make_query(i[0], i % 4, i[1], edge_pos[i], edge_pos[5 - i],
				edge_pos[(i + 2) % 6]));
		send_query(make_query(1'b0, 3, 1, 16'sd8000, 16'sd700, 16'sd3333));
	endtask

	// Ignored value write, all-dry corners with fallback, then one and then two wet corners.
	task automatic test_fluid_marks();
		set_geometry(5'd2, 5'd2, 5'd1, 1'b0);
		send_txn(make_write(ACT_WR_VALUE, 0, 0, 0, 3, 0, 32'h7FFF_FFFF, 0));
		for (int k = 0; k < 4; k++) begin
			send_txn(make_write(ACT_WR_VALUE, k[0], k[1], 0, 0, 0,
				k[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000, 0));
			send_txn(make_write(ACT_WR_FLUID, k[0], k[1], 0, 1, 0, 0, 1'b0));
		end
		send_query(make_query(1'b1, 0, 0, 16'sd1000, 16'sd900, 16'sd0));
		send_query(make_query(1'b0, 0, 0, 16'sd1000, 16'sd900, 16'sd0));
		send_txn(make_write(ACT_WR_FLUID, 1, 0, 0, 2, 0, 0, 1'b1));
		send_query(make_query(1'b1, 0, 0, 16'sd1000, 16'sd900, -16'sd1));
		send_txn(make_write(ACT_WR_FLUID, 0, 1, 0, 0, 0, 0, 1'b1));
		send_query(make_query(1'b1, 0, 0, 16'sd777, 16'sd1200, 16'sd5));
	endtask

	// Corner geometries: flat z in 3D, clamped-low and clamped-high sizes.
	task automatic test_geometry_extremes();
		set_geometry(5'd3, 5'd2, 5'd1, 1'b1);
		send_query(make_query(1'b1, 1, 1, 16'sd1500, 16'sd600, 16'sd2000));
		set_geometry(5'd0, 5'd1, 5'd0, 1'b1);
		send_query(make_query(1'b0, 2, 0, 16'sd1300, 16'sd32767, -16'sd32768));
		set_geometry(5'd31, 5'd31, 5'd31, 1'b1);
		send_query(make_query(1'b1, 0, 1, 16'sd32767, 16'sd16000, 16'sd15000));
		set_geometry(5'd17, 5'd16, 5'd2, 1'b0);
		send_query(make_query(1'b1, 1, 0, 16'sd15800, 16'sd300, 16'sd9999));
	endtask

	// Random phases over a spread of geometries; small grids dominate.
	task automatic test_random_traffic();
		logic [4:0] sx, sy, sz;
		logic td;
		int r;
		int phase_start;
		txn_t it;
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7) begin
				sx = 16; sy = 16; sz = 16; td = 1;
			end else begin
				sx = $urandom_range(0, 6);
				sy = $urandom_range(0, 6);
				sz = $urandom_range(0, 4);
				td = $urandom_range(0, 1);
				if (ph == 3) sx = $urandom_range(17, 31);
			end
			set_geometry(sx, sy, sz, td);
			no_idle = (ph == 2);
			phase_start = sent_count;
			while (sent_count - phase_start < PHASE_TXNS) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					send_query(make_query(r[0], $urandom_range(0, 3), $urandom_range(0, 1),
						rand_pos(sx), rand_pos(sy), rand_pos(sz)));
				end else if (r < 75) begin
					it = make_write(ACT_WR_VALUE, $urandom_range(0, 15), $urandom_range(0, 15),
						$urandom_range(0, 15), $urandom_range(0, 3), $urandom_range(0, 1),
						$urandom, 0);
					if (r < 65) begin
						it.x = $urandom_range(0, 5);
						it.y = $urandom_range(0, 5);
						it.z = $urandom_range(0, 3);
					end
					send_txn(it);
				end else begin
					it = make_write(ACT_WR_FLUID, $urandom_range(0, 5), $urandom_range(0, 5),
						$urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 1),
						$urandom, $urandom_range(0, 2) != 0);
					if (r > 95) begin
						it.x = $urandom_range(0, 15);
						it.y = $urandom_range(0, 15);
						it.z = $urandom_range(0, 15);
					end
					send_txn(it);
				end
			end
			no_idle = 0;
		end
	endtask

	initial begin
		err_count = 0;
		cycle_count = 0;
		sent_count = 0;
		no_idle = 0;
		stall_left = 0;
		reg_sx = 16;
		reg_sy = 16;
		reg_sz = 16;
		reg_3d = 1;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_WR_VALUE;
		req_ch.cell_x = '0;
		req_ch.cell_y = '0;
		req_ch.cell_z = '0;
		req_ch.channel = '0;
		req_ch.batch = '0;
		req_ch.cell_value = '0;
		req_ch.cell_fluid = '0;
		req_ch.pos_x = '0;
		req_ch.pos_y = '0;
		req_ch.pos_z = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_SIZE_X;
		cfg_ch.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_fluid_marks();
		test_geometry_extremes();
		test_random_traffic();
		wait_drained();

		if (err_count == 0)
			$display("fluid_aware_trilinear_interp_top test passed");
		else
			$display("fluid_aware_trilinear_interp_top test failed");
		$finish;
	end

endmodule
